// ----- hw/rtl/assert_macros.svh -----
// -----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on a rising edge and held off
// while the active-low reset is asserted.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every sampled edge.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
    else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/keymx_pkg.sv -----
// -----------------------------------------------------------------------------
// keymx_pkg
// Shared types and constants of the keypad matrix event scanner.
// -----------------------------------------------------------------------------
`default_nettype none

package keymx_pkg;

  localparam int unsigned MAX_KEYS  = 16;
  localparam int unsigned NUM_SLOTS = MAX_KEYS + 1;  // keys plus encoder
  localparam int unsigned SLOT_W    = 5;
  localparam int unsigned CODE_W    = 5;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned ENABLE_W  = 3;

  localparam logic [CODE_W-1:0] CODE_ENC_LEFT  = 5'd16;
  localparam logic [CODE_W-1:0] CODE_ENC_RIGHT = 5'd17;

  localparam logic [CFG_IDX_W-1:0] REG_PRESENT_KEYS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MS      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EVENT_ENABLE = 8'd3;

  localparam logic [15:0]         RST_PRESENT_KEYS = 16'h137F;
  localparam logic [15:0]         RST_HOLD_MS      = 16'd100;
  localparam logic [15:0]         RST_LONG_MS      = 16'd500;
  localparam logic [ENABLE_W-1:0] RST_EVENT_ENABLE = 3'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_LONG    = 2'd2
  } kind_e;

  // Per-key lane result and state view.
  typedef struct packed {
    logic  fire;
    kind_e kind;
    logic  timing;
    logic  long_rep;
  } lane_out_t;

  // Merge stage status toward the scan side.
  typedef struct packed {
    logic load_ok;
    logic busy;
  } merge_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/keymx_if.sv -----
// -----------------------------------------------------------------------------
// keymx_if
// Valid/ready channels of the scanner: scan ticks, events and config writes.
// -----------------------------------------------------------------------------
`default_nettype none

interface keymx_scan_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [15:0] key_levels;
  logic        enc_left_pin;
  logic        enc_right_pin;
  modport source (output valid, now_ms, key_levels, enc_left_pin, enc_right_pin,
                  input ready);
  modport sink   (input valid, now_ms, key_levels, enc_left_pin, enc_right_pin,
                  output ready);
endinterface

interface keymx_event_if;
  logic                         valid;
  logic                         ready;
  logic [keymx_pkg::CODE_W-1:0] key_code;
  logic [keymx_pkg::KIND_W-1:0] event_kind;
  logic                         last_of_scan;
  modport source (output valid, key_code, event_kind, last_of_scan, input ready);
  modport sink   (input valid, key_code, event_kind, last_of_scan, output ready);
endinterface

interface keymx_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [keymx_pkg::CFG_IDX_W-1:0] index;
  logic [keymx_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/keymx_lane.sv -----
// -----------------------------------------------------------------------------
// keymx_lane
// One key position: lockout timer, press stamp and long-press flag.
// -----------------------------------------------------------------------------
`default_nettype none

module keymx_lane #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         step_i,
  input  wire                         present_i,
  input  wire                         pressed_i,
  input  wire  [TIME_WIDTH-1:0]       now_i,
  input  wire  [15:0]                 hold_ms_i,
  input  wire  [15:0]                 long_ms_i,
  input  wire  [keymx_pkg::ENABLE_W-1:0] enable_i,
  output keymx_pkg::lane_out_t        lane_o
);
  import keymx_pkg::*;

  logic [TIME_WIDTH-1:0] stamp_q, stamp_d;
  logic                  timing_q, timing_d;
  logic                  long_q, long_d;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  fire;
  kind_e                 kind;

  assign elapsed = now_i - stamp_q;

  always_comb begin
    stamp_d  = stamp_q;
    timing_d = timing_q;
    long_d   = long_q;
    fire     = 1'b0;
    kind     = KIND_PRESS;
    if (present_i) begin
      if (timing_q) begin
        if (elapsed > TIME_WIDTH'(hold_ms_i)) begin
          if (!pressed_i) begin
            // released after lockout: stop timing
            timing_d = 1'b0;
            long_d   = 1'b0;
            kind     = KIND_RELEASE;
            fire     = !long_q && enable_i[KIND_RELEASE];
          end else if (elapsed > TIME_WIDTH'(long_ms_i) && !long_q) begin
            long_d = 1'b1;
            kind   = KIND_LONG;
            fire   = enable_i[KIND_LONG];
          end
        end
      end else if (pressed_i && !long_q) begin
        timing_d = 1'b1;
        stamp_d  = now_i;
        kind     = KIND_PRESS;
        fire     = enable_i[KIND_PRESS];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q  <= '0;
      timing_q <= 1'b0;
      long_q   <= 1'b0;
    end else if (step_i) begin
      stamp_q  <= stamp_d;
      timing_q <= timing_d;
      long_q   <= long_d;
    end
  end

  assign lane_o.fire     = fire;
  assign lane_o.kind     = kind;
  assign lane_o.timing   = timing_q;
  assign lane_o.long_rep = long_q;

endmodule

`default_nettype wire

// ----- hw/rtl/keymx_merge.sv -----
// -----------------------------------------------------------------------------
// keymx_merge
// Collect one tick's lane events and hand them out lowest slot first.
// -----------------------------------------------------------------------------
`default_nettype none

module keymx_merge (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   load_i,
  input  wire  [keymx_pkg::NUM_SLOTS-1:0]       fire_i,
  input  keymx_pkg::kind_e [keymx_pkg::MAX_KEYS-1:0] kind_i,
  input  wire                                   enc_right_i,
  output keymx_pkg::merge_stat_t                stat_o,
  keymx_event_if.source                         evt_o
);
  import keymx_pkg::*;

  logic [NUM_SLOTS-1:0] pend_q, pend_d;
  kind_e [MAX_KEYS-1:0] kind_q;
  logic                 enc_right_q;

  logic                 out_valid_q, out_valid_d;
  logic [CODE_W-1:0]    out_code_q, out_code_d;
  kind_e                out_kind_q, out_kind_d;
  logic                 out_last_q, out_last_d;

  logic [SLOT_W-1:0]    sel;
  logic [NUM_SLOTS-1:0] pend_after;
  logic                 move;
  logic                 last;

  // lowest pending slot
  always_comb begin
    sel = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel = SLOT_W'(i);
      end
    end
  end

  assign pend_after = pend_q & ~(NUM_SLOTS'(1) << sel);
  assign move       = (|pend_q) && (!out_valid_q || evt_o.ready);
  assign last       = (pend_after == '0);

  assign stat_o.load_ok = (pend_q == '0) || (move && last);
  assign stat_o.busy    = (pend_q != '0);

  always_comb begin
    pend_d = pend_q;
    if (load_i) begin
      pend_d = fire_i;
    end else if (move) begin
      pend_d = pend_after;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_code_d  = out_code_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    if (move) begin
      out_valid_d = 1'b1;
      out_last_d  = last;
      if (sel == SLOT_W'(MAX_KEYS)) begin
        out_code_d = enc_right_q ? CODE_ENC_RIGHT : CODE_ENC_LEFT;
        out_kind_d = KIND_PRESS;
      end else begin
        out_code_d = CODE_W'(sel);
        out_kind_d = kind_q[sel[SLOT_W-2:0]];
      end
    end else if (evt_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload: no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q      <= kind_i;
      enc_right_q <= enc_right_i;
    end
    out_code_q <= out_code_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign evt_o.valid        = out_valid_q;
  assign evt_o.key_code     = out_code_q;
  assign evt_o.event_kind   = out_kind_q;
  assign evt_o.last_of_scan = out_last_q;

endmodule

`default_nettype wire

// ----- hw/rtl/keypad_matrix_event_scanner.sv -----
// -----------------------------------------------------------------------------
// keypad_matrix_event_scanner
// Matrix keypad scanner with lockout timers, long-press detection and a
// two-pin encoder, one lane per key position feeding an event merge stage.
// -----------------------------------------------------------------------------
//   channel   dir  beat carries
//   scan_i    in   now_ms, key_levels, enc_left_pin, enc_right_pin
//   evt_o     out  key_code, event_kind, last_of_scan
//   cfg_i     in   index, data (present_keys, hold_ms, long_ms, event_enable)
//
// A scan beat updates every lane in the cycle it is taken; its events then
// leave one per cycle while evt_o is not stalled, up to 17 per tick, drained
// from the merge buffer by the single output register.
// The next scan beat is taken in the cycle the previous tick's last event
// moves to the output register; a stalled evt_o holds that register.
// Reset clears all timers, flags and the encoder arm; no clearing pass.
// -----------------------------------------------------------------------------
`default_nettype none

module keypad_matrix_event_scanner #(
  parameter int unsigned ROWS       = 4,
  parameter int unsigned COLS       = 4,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  keymx_scan_if.sink    scan_i,
  keymx_event_if.source evt_o,
  keymx_cfg_if.sink     cfg_i
);
  import keymx_pkg::*;

  // Scanned positions: never more than sixteen.
  localparam int unsigned NLANES = (ROWS * COLS < MAX_KEYS) ? ROWS * COLS : MAX_KEYS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0]         present_q;
  logic [15:0]         hold_ms_q;
  logic [15:0]         long_ms_q;
  logic [ENABLE_W-1:0] enable_q;
  logic                cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= RST_PRESENT_KEYS;
      hold_ms_q <= RST_HOLD_MS;
      long_ms_q <= RST_LONG_MS;
      enable_q  <= RST_EVENT_ENABLE;
    end else if (cfg_we) begin
      case (cfg_i.index)
        REG_PRESENT_KEYS: present_q <= cfg_i.data;
        REG_HOLD_MS:      hold_ms_q <= cfg_i.data;
        REG_LONG_MS:      long_ms_q <= cfg_i.data;
        REG_EVENT_ENABLE: enable_q  <= cfg_i.data[ENABLE_W-1:0];
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Scan handshake
  // ---------------------------------------------------------------------------
  merge_stat_t           mstat;
  logic                  scan_acc;
  logic [TIME_WIDTH-1:0] now;

  assign scan_i.ready = mstat.load_ok;
  assign scan_acc     = scan_i.valid && scan_i.ready;
  assign now          = scan_i.now_ms[TIME_WIDTH-1:0];

  // ---------------------------------------------------------------------------
  // Key lanes: one per scanned position, all evaluated on the same beat
  // ---------------------------------------------------------------------------
  lane_out_t [NLANES-1:0]   lane;
  logic [NUM_SLOTS-1:0]     fire;
  kind_e [MAX_KEYS-1:0]     kinds;
  logic [MAX_KEYS-1:0]      timing_vec;
  logic [MAX_KEYS-1:0]      long_vec;

  for (genvar p = 0; p < MAX_KEYS; p++) begin : g_key
    if (p < NLANES) begin : g_lane
      keymx_lane #(
        .TIME_WIDTH (TIME_WIDTH)
      ) u_lane (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .step_i    (scan_acc),
        .present_i (present_q[p]),
        .pressed_i (!scan_i.key_levels[p]),
        .now_i     (now),
        .hold_ms_i (hold_ms_q),
        .long_ms_i (long_ms_q),
        .enable_i  (enable_q),
        .lane_o    (lane[p])
      );
      assign fire[p]       = lane[p].fire;
      assign kinds[p]      = lane[p].kind;
      assign timing_vec[p] = lane[p].timing;
      assign long_vec[p]   = lane[p].long_rep;
    end else begin : g_absent
      assign fire[p]       = 1'b0;
      assign kinds[p]      = KIND_PRESS;
      assign timing_vec[p] = 1'b0;
      assign long_vec[p]   = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Encoder: arm on both pins high, fire on the first single-pin level
  // ---------------------------------------------------------------------------
  logic armed_q, armed_d;
  logic enc_step;
  logic enc_right;

  always_comb begin
    armed_d   = armed_q;
    enc_step  = 1'b0;
    enc_right = 1'b0;
    if (scan_i.enc_left_pin && scan_i.enc_right_pin) begin
      armed_d = 1'b1;
    end else if (armed_q && (scan_i.enc_left_pin != scan_i.enc_right_pin)) begin
      armed_d   = 1'b0;
      enc_step  = 1'b1;
      enc_right = scan_i.enc_right_pin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
    end else if (scan_acc) begin
      armed_q <= armed_d;
    end
  end

  // encoder events are press kind and follow the press enable
  assign fire[MAX_KEYS] = enc_step && enable_q[KIND_PRESS];

  // ---------------------------------------------------------------------------
  // Merge: buffer this tick's events, hand out in scan order
  // ---------------------------------------------------------------------------
  keymx_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (scan_acc),
    .fire_i      (fire),
    .kind_i      (kinds),
    .enc_right_i (enc_right),
    .stat_o      (mstat),
    .evt_o       (evt_o)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "assert_macros.svh"

  // a long flag only ever stands on a key whose timer runs
  `ASSERT_ALWAYS(a_long_needs_timing, clk_i, rst_ni, ((long_vec & ~timing_vec) == '0),
                 "long flag set on a key that is not timing")

  // an event that is not last of its tick leaves more behind in the buffer
  `ASSERT_IMPLIES(a_more_pending, clk_i, rst_ni, evt_o.valid && !evt_o.last_of_scan,
                  mstat.busy, "non-final event with empty merge buffer")

  // a new tick is never taken while events other than the outgoing one wait
  `ASSERT_IMPLIES(a_no_overrun, clk_i, rst_ni, scan_acc && mstat.busy,
                  $countones(u_merge.pend_q) == 1, "scan taken over pending events")

endmodule

`default_nettype wire

// ----- tb/keypad_matrix_event_scanner_test.sv -----
// ----------------------------------------------------------------------------
// keypad_matrix_event_scanner_test
// Self-checking bench for the keypad scanner. A local model of the lockout
// timers, long-press flags and encoder arm predicts the events of every scan
// tick. Each event beat is compared against the oldest prediction. Directed
// ticks cover the edge cases, followed by random key and encoder traffic
// under several configurations and back-pressure mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_matrix_event_scanner_test;
  timeunit 1ns;
  timeprecision 1ps;

  import keymx_pkg::*;

  localparam int unsigned ROWS       = 4;
  localparam int unsigned COLS       = 4;
  localparam int unsigned TIME_WIDTH = 32;
  localparam int unsigned NUM_KEYS   = ROWS * COLS;

  // Slack for the block to settle after the last predicted event, before
  // the config port is touched.
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  // Index that maps to no register; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hA5;

  typedef struct {
    logic [CODE_W-1:0] code;
    kind_e             kind;
    logic              is_last;
  } key_event_t;

  logic clk;
  logic rst_n;

  keymx_scan_if  scan_bus ();
  keymx_event_if evt_bus ();
  keymx_cfg_if   cfg_bus ();

  keypad_matrix_event_scanner #(
    .ROWS       (ROWS),
    .COLS       (COLS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .scan_i (scan_bus),
    .evt_o  (evt_bus),
    .cfg_i  (cfg_bus)
  );

  // Model copy of the configuration registers.
  logic [15:0]         cfg_present;
  logic [15:0]         cfg_hold;
  logic [15:0]         cfg_long;
  logic [ENABLE_W-1:0] cfg_enable;

  // Model copy of the per-key timers and the encoder arm.
  logic [31:0] press_stamp [NUM_KEYS];
  logic [15:0] key_timing;
  logic [15:0] long_done;
  logic        enc_armed;

  key_event_t pending_events [$];
  key_event_t tick_events [$];

  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  bit          scan_up;

  // State of the random stimulus: time base, held keys and encoder walk.
  logic [31:0] sim_ms;
  logic [15:0] held_keys;
  int unsigned enc_phase;
  logic        enc_dir;

  always #10 clk = ~clk;

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 200) $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Event model
  // ---------------------------------------------------------------------------

  // Queue one event of the current tick if its kind is enabled.
  function automatic void add_event(input logic [CODE_W-1:0] code, input kind_e kind);
    if (cfg_enable[int'(kind)]) tick_events.push_back('{code: code, kind: kind, is_last: 1'b0});
  endfunction

  // Advance the model by one scan tick and queue the events it gives.
  function automatic void predict_scan_events(input logic [31:0] now, input logic [15:0] levels,
                                              input logic left, input logic right);
    logic [31:0] elapsed;
    logic        pressed;
    tick_events.delete();
    for (int p = 0; p < NUM_KEYS; p++) begin
      pressed = !levels[p];
      // Absent keys keep their timer frozen until they are present again.
      if (cfg_present[p]) begin
        if (key_timing[p]) begin
          elapsed = now - press_stamp[p];
          if (elapsed > {16'd0, cfg_hold}) begin
            if (!pressed) begin
              key_timing[p] = 1'b0;
              // A press that already reported Long ends silently.
              if (!long_done[p]) add_event(CODE_W'(p), KIND_RELEASE);
              long_done[p] = 1'b0;
            end else if (elapsed > {16'd0, cfg_long} && !long_done[p]) begin
              add_event(CODE_W'(p), KIND_LONG);
              long_done[p] = 1'b1;
            end
          end
        end else if (pressed && !long_done[p]) begin
          key_timing[p]  = 1'b1;
          press_stamp[p] = now;
          add_event(CODE_W'(p), KIND_PRESS);
        end
      end
    end

    // Encoder comes last: arm on both high, fire on a single pin.
    if (left && right) begin
      enc_armed = 1'b1;
    end else if (enc_armed && left && !right) begin
      enc_armed = 1'b0;
      add_event(CODE_ENC_LEFT, KIND_PRESS);
    end else if (enc_armed && !left && right) begin
      enc_armed = 1'b0;
      add_event(CODE_ENC_RIGHT, KIND_PRESS);
    end

    if (tick_events.size() > 0) tick_events[tick_events.size()-1].is_last = 1'b1;
    foreach (tick_events[i]) pending_events.push_back(tick_events[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offer one scan beat, with a random gap first; valid stays high after the
  // beat so back-to-back ticks need no drop in between.
  task automatic send_scan(input logic [31:0] now, input logic [15:0] levels,
                           input logic left, input logic right);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      scan_bus.valid <= 1'b0;
      @(posedge clk);
    end
    scan_bus.valid         <= 1'b1;
    scan_bus.now_ms        <= now;
    scan_bus.key_levels    <= levels;
    scan_bus.enc_left_pin  <= left;
    scan_bus.enc_right_pin <= right;
    scan_up = 1'b1;
    do @(posedge clk); while (!scan_bus.ready);
    predict_scan_events(now, levels, left, right);
  endtask

  // Drop valid, wait for every predicted event, then let the block settle.
  task automatic wait_idle();
    if (scan_up) begin
      scan_bus.valid <= 1'b0;
      scan_up = 1'b0;
    end
    while (pending_events.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DAT_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (index)
      REG_PRESENT_KEYS: cfg_present = data;
      REG_HOLD_MS:      cfg_hold    = data;
      REG_LONG_MS:      cfg_long    = data;
      REG_EVENT_ENABLE: cfg_enable  = data[ENABLE_W-1:0];
      default: ;
    endcase
  endtask

  // Write the full register set, plus a stray index that must be ignored.
  // Only the low bits of the enable word count; the rest is noise.
  task automatic apply_config(input logic [15:0] present, input logic [15:0] hold,
                              input logic [15:0] long_lim, input logic [15:0] enable_word);
    write_reg(REG_UNUSED, 16'($urandom));
    write_reg(REG_PRESENT_KEYS, present);
    write_reg(REG_HOLD_MS, hold);
    write_reg(REG_LONG_MS, long_lim);
    write_reg(REG_EVENT_ENABLE, enable_word);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Event checker and sink back-pressure
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    key_event_t want;
    if (rst_n && evt_bus.valid && evt_bus.ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event code=%0d kind=%0d last=%0b",
                                  evt_bus.key_code, evt_bus.event_kind, evt_bus.last_of_scan));
      end else begin
        want = pending_events.pop_front();
        if (evt_bus.key_code !== want.code || evt_bus.event_kind !== want.kind ||
            evt_bus.last_of_scan !== want.is_last)
          report_mismatch($sformatf("event got code=%0d kind=%0d last=%0b, want %0d/%0d/%0b",
                                    evt_bus.key_code, evt_bus.event_kind, evt_bus.last_of_scan,
                                    want.code, want.kind, want.is_last));
      end
    end
    evt_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values: sparse key map, only Press enabled.
  task automatic test_reset_defaults();
    send_scan(32'd0, 16'h0000, 1'b1, 1'b1);   // zero stamp is a real time
    send_scan(32'd50, 16'hFFFF, 1'b1, 1'b0);  // still in lockout; encoder left
    send_scan(32'd101, 16'hFFFF, 1'b0, 1'b1); // silent releases, encoder disarmed
    wait_idle();
  endtask

  // Full matrix: the 17-event tick, Long, and the quiet end of a long press.
  task automatic test_full_matrix();
    apply_config(16'hFFFF, 16'd10, 16'd30, 16'h0007);
    send_scan(32'd150, 16'hFFFF, 1'b1, 1'b1);
    send_scan(32'd200, 16'h0000, 1'b1, 1'b0);
    send_scan(32'd211, 16'h0000, 1'b0, 1'b0);
    send_scan(32'd231, 16'h0000, 1'b0, 1'b0);
    send_scan(32'd240, 16'hFFFF, 1'b1, 1'b1);
    send_scan(32'd241, 16'h5555, 1'b0, 1'b1);
    wait_idle();
  endtask

  // Press stamped just below the wrap of the millisecond counter.
  task automatic test_time_wrap();
    send_scan(32'hFFFF_FFF0, 16'hFFFF, 1'b0, 1'b0);
    send_scan(32'hFFFF_FFF8, 16'h0000, 1'b0, 1'b0);
    send_scan(32'h0000_0004, 16'h0000, 1'b0, 1'b0);
    send_scan(32'h0000_0020, 16'h0000, 1'b0, 1'b0);
    send_scan(32'h0000_0030, 16'hFFFF, 1'b0, 1'b0);
    wait_idle();
  endtask

  // Upper keys leave the map mid-press and must resume when they return.
  task automatic test_key_removed();
    send_scan(32'h40, 16'h0000, 1'b0, 1'b0);
    wait_idle();
    apply_config(16'h00FF, 16'd10, 16'd30, 16'h0007);
    send_scan(32'h60, 16'hFFFF, 1'b0, 1'b0);
    wait_idle();
    apply_config(16'hFFFF, 16'd10, 16'd30, 16'h0007);
    send_scan(32'h61, 16'hFFFF, 1'b0, 1'b0);
    wait_idle();
  endtask

  // Zero and full-scale timers, a release-only mask and a closed mask.
  task automatic test_timer_extremes();
    apply_config(16'hFFFF, 16'd0, 16'd0, 16'h0007);
    send_scan(32'h100, 16'h0000, 1'b0, 1'b0);
    send_scan(32'h100, 16'h0000, 1'b0, 1'b0);
    send_scan(32'h101, 16'h0000, 1'b0, 1'b0);
    send_scan(32'h102, 16'hFFFF, 1'b0, 1'b0);
    wait_idle();
    apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFA);
    send_scan(32'h200, 16'h0000, 1'b0, 1'b0);
    send_scan(32'h200 + 32'd65535, 16'hFFFF, 1'b0, 1'b0);
    send_scan(32'h200 + 32'd65536, 16'hFFFF, 1'b0, 1'b0);
    wait_idle();
    apply_config(16'hFFFF, 16'd5, 16'd8, 16'hFFF8);
    send_scan(32'h300, 16'h0000, 1'b1, 1'b1);
    send_scan(32'h310, 16'h0000, 1'b1, 1'b0);
    wait_idle();
  endtask

  task automatic apply_random_config();
    logic [15:0] present;
    logic [15:0] hold;
    logic [15:0] long_lim;
    logic [15:0] enable_word;
    present = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'hFFFF;
    case ($urandom_range(0, 5))
      0:       hold = 16'd0;
      1:       hold = 16'hFFFF;
      default: hold = 16'($urandom_range(0, 12));
    endcase
    case ($urandom_range(0, 5))
      0:       long_lim = 16'd0;
      1:       long_lim = 16'hFFFF;
      default: long_lim = 16'($urandom_range(0, 40));
    endcase
    enable_word = {13'($urandom), 3'($urandom_range(1, 7))};
    apply_config(present, hold, long_lim, enable_word);
  endtask

  // Keys are held and let go over several ticks so timers run their full
  // course; some ticks carry raw noise levels or jumps in time.
  task automatic run_random_ticks(input int unsigned count);
    logic [15:0] levels;
    logic        left;
    logic        right;
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) sim_ms = $urandom;
      else if (pick < 9) sim_ms = sim_ms + $urandom_range(0, 70000);
      else sim_ms = sim_ms + $urandom_range(0, 4);

      held_keys = held_keys ^ 16'($urandom & $urandom & $urandom);
      levels = ($urandom_range(0, 9) == 0) ? 16'($urandom) : ~held_keys;

      // Walk the encoder through arm, turn and rest, with some noise.
      if ($urandom_range(0, 6) == 0) begin
        left  = 1'($urandom);
        right = 1'($urandom);
      end else begin
        case (enc_phase)
          0: begin
            left  = 1'b1;
            right = 1'b1;
          end
          1: begin
            left  = enc_dir;
            right = !enc_dir;
          end
          default: begin
            left  = 1'b0;
            right = 1'b0;
          end
        endcase
        if ($urandom_range(0, 2) != 0) begin
          enc_phase = (enc_phase + 1) % 3;
          if (enc_phase == 1) enc_dir = 1'($urandom);
        end
      end

      send_scan(sim_ms, levels, left, right);
      // Now and then hold the sender until the event stream runs dry.
      if ($urandom_range(0, 39) == 0) wait_idle();
    end
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct  = 31;
          sink_idle_pct = 74;
        end
        1: begin
          src_idle_pct  = 74;
          sink_idle_pct = 31;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 2; s++) begin
        wait_idle();
        apply_random_config();
        run_random_ticks(66);
      end
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    scan_up        = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    src_idle_pct   = 31;
    sink_idle_pct  = 74;

    scan_bus.valid         = 1'b0;
    scan_bus.now_ms        = '0;
    scan_bus.key_levels    = 16'hFFFF;
    scan_bus.enc_left_pin  = 1'b0;
    scan_bus.enc_right_pin = 1'b0;
    evt_bus.ready          = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = '0;
    cfg_bus.data           = '0;

    cfg_present = RST_PRESENT_KEYS;
    cfg_hold    = RST_HOLD_MS;
    cfg_long    = RST_LONG_MS;
    cfg_enable  = RST_EVENT_ENABLE;
    foreach (press_stamp[i]) press_stamp[i] = '0;
    key_timing = '0;
    long_done  = '0;
    enc_armed  = 1'b0;

    sim_ms    = 32'h1000;
    held_keys = '0;
    enc_phase = 0;
    enc_dir   = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_full_matrix();
    test_time_wrap();
    test_key_removed();
    test_timer_extremes();
    test_random_traffic();

    // Catch stray events that trail the last prediction.
    repeat (20) @(posedge clk);
    if (pending_events.size() != 0)
      report_mismatch($sformatf("%0d events never arrived", pending_events.size()));

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
